/* src/dtr_pkg.sv */
// dtr_pkg: widths, fixed-point constants, the divider request type and
// the arctangent table shared by the resonator datapath.
// No dependencies.
package dtr_pkg;

  // field widths
  localparam int SampleW = 24;
  localparam int StateW  = 48;
  localparam int FreqW   = 17;
  localparam int DecayW  = 16;
  localparam int NyqW    = 17;

  // shared divider geometry
  localparam int DivNumW = 60;
  localparam int DivDenW = 38;
  localparam int DivQW   = 31;
  localparam int DivCntW = 5;

  // cordic geometry
  localparam int CordW     = 34;
  localparam int CordSteps = 30;

  // fixed-point constants
  localparam logic [28:0] QScale    = 29'd500049222;
  localparam logic [37:0] QFloor    = 38'd6554;
  localparam logic [31:0] PiQ30     = 32'd3373259426;
  localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
  localparam logic [30:0] OneQ30    = 31'd1073741824;
  localparam logic [29:0] KInvQ30   = 30'd652032874;
  localparam logic [31:0] OneQ28    = 32'd268435456;
  localparam logic [16:0] NyqReset  = 17'd24000;

  // request to the shared divider
  typedef struct packed {
    logic                 start;
    logic [DivNumW-1:0]   num;
    logic [DivDenW-1:0]   den;
    logic [DivCntW-1:0]   qbits;
  } dtr_div_req_t;

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] dtr_atan(input logic [DivCntW-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd843314857;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043837;
      5'd3:    r = 30'd133525159;
      5'd4:    r = 30'd67021687;
      5'd5:    r = 30'd33543516;
      5'd6:    r = 30'd16775851;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194283;
      5'd9:    r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

/* src/dtr_div.sv */
// dtr_div: unsigned restoring divider, one quotient bit per cycle.
// The caller gives the quotient width; the dividend must fit below den*2^qbits.
// Depends on dtr_pkg.
module dtr_div import dtr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtr_div_req_t       req_i,
  output logic               done_o,
  output logic [DivQW-1:0]   quot_o
);

  logic [DivDenW-1:0] rem_q;
  logic [DivNumW-1:0] low_q;
  logic [DivDenW-1:0] den_q;
  logic [DivQW-1:0]   quot_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DivNumW-1:0] num_hi;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               ge;

  // one restoring step
  always_comb begin
    num_hi = req_i.num >> req_i.qbits;
    trial  = {rem_q, low_q[DivNumW-1]};
    diff   = trial - {1'b0, den_q};
    ge     = (trial >= {1'b0, den_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.qbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= num_hi[DivDenW-1:0];
      low_q  <= req_i.num << (6'd60 - {1'b0, req_i.qbits});
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      low_q  <= low_q << 1;
      quot_q <= {quot_q[DivQW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* src/dtr_cordic.sv */
// dtr_cordic: iterative rotation-mode cordic giving sin and cos of an angle
// in 0..pi (Q2.30), one iteration per cycle. Depends on dtr_pkg.
module dtr_cordic import dtr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        theta_i,
  output logic               done_o,
  output logic [30:0]        sin_o,
  output logic signed [31:0] cos_o
);

  localparam logic signed [CordW-1:0] OneS = CordW'(signed'({1'b0, OneQ30}));

  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic [DivCntW-1:0]      i_q;
  logic                    flip_q;
  logic                    busy_q;
  logic                    done_q;

  logic signed [CordW-1:0] sx, sy, at;
  logic signed [CordW-1:0] xc;
  logic signed [CordW-1:0] xn;

  // shifted operands for this iteration
  always_comb begin
    sx = x_q >>> i_q;
    sy = y_q >>> i_q;
    at = $signed({4'b0, dtr_atan(i_q)});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(CordSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // rotation
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= (theta_i > HalfPiQ30);
      z_q    <= (theta_i > HalfPiQ30) ? $signed({2'b0, PiQ30 - theta_i})
                                      : $signed({2'b0, theta_i});
      x_q    <= $signed({4'b0, KInvQ30});
      y_q    <= '0;
    end else if (busy_q) begin
      if (!z_q[CordW-1]) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + at;
      end
    end
  end

  // clamp and fold back to the upper quadrant
  always_comb begin
    if (y_q[CordW-1])    sin_o = '0;
    else if (y_q > OneS) sin_o = OneQ30;
    else                 sin_o = y_q[30:0];
    if (x_q > OneS)       xc = OneS;
    else if (x_q < -OneS) xc = -OneS;
    else                  xc = x_q;
    xn    = flip_q ? -xc : xc;
    cos_o = xn[31:0];
  end

  assign done_o = done_q;

endmodule

/* src/decay_time_resonator_biquad.sv */
// decay_time_resonator_biquad: band-pass resonator tuned by frequency and T60.
// Depends on dtr_pkg, dtr_div, dtr_cordic.
//
// Each input transaction (sample, frequency, decay time) is worked through by a
// sequencer from acceptance until its result is ready; in_ready_o is high only
// while the block is idle. Most of that work is done by the shared radix-2
// divider, which runs five divisions one quotient bit per cycle, and by
// the 30-iteration cordic; the few multiplications go through one registered
// 33x33 multiplier. The result sits in an output register, so the next
// transaction is taken while a result still waits. nyquist_hz resets to 24000
// and may be written only while the block is idle.
module decay_time_resonator_biquad import dtr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [NyqW-1:0]           cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  input  logic [FreqW-1:0]          freq_hz_i,
  input  logic [DecayW-1:0]         decay_ms_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] sample_out_o
);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_FT   = 5'd1;
  localparam logic [4:0] S_QL   = 5'd2;
  localparam logic [4:0] S_QH   = 5'd3;
  localparam logic [4:0] S_QS   = 5'd4;
  localparam logic [4:0] S_RW   = 5'd5;
  localparam logic [4:0] S_TH   = 5'd6;
  localparam logic [4:0] S_TM   = 5'd7;
  localparam logic [4:0] S_CW   = 5'd8;
  localparam logic [4:0] S_AL   = 5'd9;
  localparam logic [4:0] S_AW   = 5'd10;
  localparam logic [4:0] S_A0   = 5'd11;
  localparam logic [4:0] S_A0G  = 5'd12;
  localparam logic [4:0] S_A0W  = 5'd13;
  localparam logic [4:0] S_B1G  = 5'd14;
  localparam logic [4:0] S_B1W  = 5'd15;
  localparam logic [4:0] S_B2G  = 5'd16;
  localparam logic [4:0] S_B2W  = 5'd17;
  localparam logic [4:0] S_FA   = 5'd18;
  localparam logic [4:0] S_F1H  = 5'd19;
  localparam logic [4:0] S_F1L  = 5'd20;
  localparam logic [4:0] S_F1S  = 5'd21;
  localparam logic [4:0] S_F2L  = 5'd22;
  localparam logic [4:0] S_F2S  = 5'd23;
  localparam logic [4:0] S_DONE = 5'd24;

  localparam logic signed [55:0] StHi = 56'sh7FFF_FFFF_FFFF;
  localparam logic signed [55:0] StLo = -StHi - 56'sd1;
  localparam logic signed [47:0] OutHi = 48'sh7F_FFFF;
  localparam logic signed [47:0] OutLo = -OutHi - 48'sd1;

  logic [4:0] state_q, state_d;

  logic [NyqW-1:0]           nyq_q;
  logic signed [SampleW-1:0] x_q;
  logic [FreqW-1:0]          f_q;
  logic [DecayW-1:0]         t60_q;
  logic [16:0]               fthi_q;
  logic signed [79:0]        acc_q;
  logic [37:0]               q_q;
  logic [30:0]               alpha_q;
  logic [31:0]               b0_q;
  logic [27:0]               a0_q;
  logic signed [30:0]        b1_q;
  logic signed [29:0]        b2_q;
  logic signed [55:0]        sum_q;

  logic signed [SampleW-1:0] x1_q, x2_q;
  logic signed [StateW-1:0]  y1_q, y2_q;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;

  dtr_div_req_t     div_req;
  logic             div_done;
  logic [DivQW-1:0] div_quot;

  logic               cor_start;
  logic [31:0]        theta;
  logic               cor_done;
  logic [30:0]        sn;
  logic signed [31:0] cs;

  logic [61:0]        qprod;
  logic [37:0]        qraw;
  logic signed [24:0] xdiff;
  logic signed [31:0] cs_abs;
  logic signed [32:0] bnum;
  logic signed [32:0] bnum_abs;
  logic signed [55:0] fb_sum;
  logic signed [47:0] y_sat;
  logic signed [47:0] y_half;
  logic               out_free;

  dtr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  dtr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .theta_i (theta),
    .done_o  (cor_done),
    .sin_o   (sn),
    .cos_o   (cs)
  );

  // derived values
  always_comb begin
    qprod    = {mul_q[45:0], 16'b0} + {17'b0, acc_q[44:0]};
    qraw     = qprod[61:24];
    xdiff    = 25'(x_q) - 25'(x2_q);
    cs_abs   = cs[31] ? -cs : cs;
    bnum     = $signed({1'b0, OneQ28}) - $signed({2'b0, alpha_q});
    bnum_abs = bnum[32] ? -bnum : bnum;
    theta    = (nyq_q == '0) ? 32'd0 : mul_q[61:30];
    fb_sum   = 56'((acc_q + 80'(mul_q)) >>> 28);
    if (sum_q > StHi)      y_sat = StHi[47:0];
    else if (sum_q < StLo) y_sat = StLo[47:0];
    else                   y_sat = sum_q[47:0];
    y_half   = y_sat >>> 1;
    out_free = !out_valid_q || out_ready_i;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_FT: begin
        mul_a = $signed({16'b0, f_q});
        mul_b = $signed({17'b0, t60_q});
      end
      S_QL: begin
        mul_a = $signed({17'b0, mul_q[15:0]});
        mul_b = $signed({4'b0, QScale});
      end
      S_QH: begin
        mul_a = $signed({16'b0, fthi_q});
        mul_b = $signed({4'b0, QScale});
      end
      S_TH: begin
        mul_a = $signed({2'b0, div_quot});
        mul_b = $signed({1'b0, PiQ30});
      end
      S_FA: begin
        mul_a = $signed({5'b0, a0_q});
        mul_b = 33'(xdiff);
      end
      S_F1H: begin
        mul_a = 33'(b1_q);
        mul_b = 33'($signed(y1_q[47:24]));
      end
      S_F1L: begin
        mul_a = 33'(b1_q);
        mul_b = $signed({9'b0, y1_q[23:0]});
      end
      S_F1S: begin
        mul_a = 33'(b2_q);
        mul_b = 33'($signed(y2_q[47:24]));
      end
      S_F2L: begin
        mul_a = 33'(b2_q);
        mul_b = $signed({9'b0, y2_q[23:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider and cordic requests
  always_comb begin
    div_req   = '0;
    cor_start = (state_q == S_TM);
    case (state_q)
      S_QS: begin
        div_req.start = 1'b1;
        div_req.num   = {13'b0, f_q, 30'b0};
        div_req.den   = {21'b0, nyq_q};
        div_req.qbits = 5'd31;
      end
      S_AL: begin
        div_req.start = 1'b1;
        div_req.num   = {16'b0, sn, 13'b0};
        div_req.den   = q_q;
        div_req.qbits = 5'd31;
      end
      S_A0G: begin
        div_req.start = 1'b1;
        div_req.num   = {4'b0, sn, 25'b0};
        div_req.den   = {6'b0, b0_q};
        div_req.qbits = 5'd28;
      end
      S_B1G: begin
        div_req.start = 1'b1;
        div_req.num   = {2'b0, cs_abs[30:0], 27'b0};
        div_req.den   = {6'b0, b0_q};
        div_req.qbits = 5'd30;
      end
      S_B2G: begin
        div_req.start = 1'b1;
        div_req.num   = {bnum_abs[31:0], 28'b0};
        div_req.den   = {6'b0, b0_q};
        div_req.qbits = 5'd29;
      end
      default: div_req = '0;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_FT;
      S_FT:    state_d = S_QL;
      S_QL:    state_d = S_QH;
      S_QH:    state_d = S_QS;
      S_QS:    state_d = S_RW;
      S_RW:    if (div_done) state_d = S_TH;
      S_TH:    state_d = S_TM;
      S_TM:    state_d = S_CW;
      S_CW:    if (cor_done) state_d = S_AL;
      S_AL:    state_d = S_AW;
      S_AW:    if (div_done) state_d = S_A0;
      S_A0:    state_d = S_A0G;
      S_A0G:   state_d = S_A0W;
      S_A0W:   if (div_done) state_d = S_B1G;
      S_B1G:   state_d = S_B1W;
      S_B1W:   if (div_done) state_d = S_B2G;
      S_B2G:   state_d = S_B2W;
      S_B2W:   if (div_done) state_d = S_FA;
      S_FA:    state_d = S_F1H;
      S_F1H:   state_d = S_F1L;
      S_F1L:   state_d = S_F1S;
      S_F1S:   state_d = S_F2L;
      S_F2L:   state_d = S_F2S;
      S_F2S:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control, configuration, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nyq_q       <= NyqReset;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) nyq_q <= cfg_data_i;
      if (state_q == S_DONE && out_free) begin
        x2_q        <= x1_q;
        x1_q        <= x_q;
        y2_q        <= y1_q;
        y1_q        <= y_sat;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= 66'(mul_a) * 66'(mul_b);
    case (state_q)
      S_IDLE: begin
        x_q   <= sample_in_i;
        f_q   <= (freq_hz_i > nyq_q) ? nyq_q : freq_hz_i;
        t60_q <= decay_ms_i;
      end
      S_QL: fthi_q <= mul_q[32:16];
      S_QH: acc_q  <= 80'(mul_q);
      S_QS: q_q    <= (qraw < QFloor) ? QFloor : qraw;
      S_A0: begin
        alpha_q <= div_quot;
        b0_q    <= OneQ28 + {1'b0, div_quot};
      end
      S_B1G: a0_q <= div_quot[27:0];
      S_B2G: b1_q <= cs[31] ? $signed({1'b0, div_quot[29:0]})
                            : -$signed({1'b0, div_quot[29:0]});
      S_FA:  b2_q <= bnum[32] ? -$signed({1'b0, div_quot[28:0]})
                              : $signed({1'b0, div_quot[28:0]});
      S_F1H: sum_q <= 56'(mul_q >>> 27);
      S_F1L: acc_q <= 80'(mul_q) <<< 24;
      S_F1S: sum_q <= sum_q - fb_sum;
      S_F2L: acc_q <= 80'(mul_q) <<< 24;
      S_F2S: sum_q <= sum_q - fb_sum;
      S_DONE: begin
        if (out_free) begin
          if (y_half > OutHi)      out_q <= OutHi[23:0];
          else if (y_half < OutLo) out_q <= OutLo[23:0];
          else                     out_q <= y_half[23:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

/* sim/testbench.sv */
// testbench for decay_time_resonator_biquad: directed table, then random transactions
// checked against a bit-accurate fixed-point predictor of the resonator.
// Depends on dtr_pkg and the resonator RTL.
module testbench;
  import dtr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 300;
  localparam int CycleLimit   = 3000000;
  localparam int RandPerPhase = 130;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic [FreqW-1:0]          freq;
    logic [DecayW-1:0]         decay;
    bit                        has_out;
    logic signed [SampleW-1:0] out_val;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [NyqW-1:0]           cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_in_i = '0;
  logic [FreqW-1:0]          freq_hz_i = '0;
  logic [DecayW-1:0]         decay_ms_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;

  logic signed [SampleW-1:0] expected_samples[$];
  int         error_count = 0;
  int         cycle_count = 0;
  idle_mode_e idle_mode = IDLE_NONE;

  // resonator state as the predictor sees it
  longint nyq_reg, x_prev1, x_prev2, y_prev1, y_prev2;
  longint atan_tbl[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  decay_time_resonator_biquad DUT (.*);

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // exact floor(c*y/2^28)
  function automatic longint coef_product(longint c, longint y);
    longint yh, yl, a, b;
    yh = y >>> 24;
    yl = y & 64'hFFFFFF;
    a  = c * yh;
    b  = c * yl;
    return (a >>> 4) + (((a & 15) * (64'sd1 <<< 24) + b) >>> 28);
  endfunction

  // one filter step: coefficients from freq and T60, then direct form I
  function automatic logic signed [SampleW-1:0] resonate(logic signed [SampleW-1:0] s,
      logic [FreqW-1:0] fr, logic [DecayW-1:0] dc);
    longint unsigned f, qu, r;
    longint xn, q, theta, x, y, z, t, sn, cs, alpha, b0, a0, b1, b2, yn;
    bit flip;
    xn = longint'(s);
    f = 64'(fr);
    if (f > nyq_reg) f = nyq_reg;
    qu = (f * longint'(dc) * 64'd500049222) >> 24;
    q = (qu < 6554) ? 6554 : longint'(qu);
    theta = 0;
    if (nyq_reg != 0) begin
      r = (f << 30) / longint'(nyq_reg);
      theta = longint'((r * 64'd3373259426) >> 30);
    end
    // cordic rotation, folded into the first quadrant
    flip = theta > 1686629713;
    if (flip) theta = 64'sd3373259426 - theta;
    x = 652032874;
    y = 0;
    z = theta;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tbl[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tbl[i];
      end
      x = t;
    end
    sn = clamp(y, 0, 1073741824);
    cs = clamp(x, -1073741824, 1073741824);
    if (flip) cs = -cs;
    // band-pass coefficients in Q3.28
    alpha = (sn <<< 13) / q;
    b0 = (64'sd1 <<< 28) + alpha;
    a0 = (sn <<< 25) / b0;
    b1 = -((cs * (64'sd1 <<< 27)) / b0);
    b2 = (((64'sd1 <<< 28) - alpha) * (64'sd1 <<< 28)) / b0;
    yn = ((a0 * (xn - x_prev2)) >>> 27) - coef_product(b1, y_prev1)
         - coef_product(b2, y_prev2);
    yn = clamp(yn, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    x_prev2 = x_prev1;
    x_prev1 = xn;
    y_prev2 = y_prev1;
    y_prev1 = yn;
    return SampleW'(clamp(yn >>> 1, -8388608, 8388607));
  endfunction

  // result side: random stall in the receiver idle modes, check each accepted transaction
  always @(negedge clk_i) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ready_i <= ($urandom_range(99) >= 56);
      IDLE_BOTH:     out_ready_i <= ($urandom_range(99) >= 9);
      default:       out_ready_i <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected output sample_out=%0d", $realtime, sample_out_o);
        error_count++;
      end else begin
        if (sample_out_o !== expected_samples[0]) begin
          $display("%0t: sample_out expected %0d actual %0d", $realtime,
                   expected_samples[0], sample_out_o);
          error_count++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  // send one transaction, with sender gaps as the idle mode asks
  task automatic send_item(stim_row_t row);
    int gap_pct;
    logic signed [SampleW-1:0] predicted;
    gap_pct = (idle_mode == IDLE_SENDER) ? 56 : (idle_mode == IDLE_BOTH) ? 9 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= row.sample;
    freq_hz_i   <= row.freq;
    decay_ms_i  <= row.decay;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = resonate(row.sample, row.freq, row.decay);
    if (row.has_out && predicted !== row.out_val) begin
      $display("%0t: table entry expected %0d, predictor gives %0d", $realtime,
               row.out_val, predicted);
      error_count++;
    end
    expected_samples.push_back(row.has_out ? row.out_val : predicted);
    @(negedge clk_i);
  endtask

  // write nyquist_hz once everything has drained
  task automatic write_nyquist(logic [NyqW-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    nyq_reg = longint'(value);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    case ($urandom_range(9))
      0:       row.sample = 24'sh7FFFFF;
      1:       row.sample = 24'sh800000;
      default: row.sample = SampleW'($urandom);
    endcase
    row.freq  = ($urandom_range(3) == 0) ? FreqW'($urandom)
                                         : FreqW'($urandom_range(int'(nyq_reg) + 100));
    row.decay = ($urandom_range(1) == 0) ? DecayW'($urandom_range(2000))
                                         : DecayW'($urandom);
    row.has_out = 1'b0;
    return row;
  endfunction

  stim_row_t directed[$] = '{
    '{24'sd0,       17'd1000,   16'd100,   1'b1, 24'sd0},
    '{24'sh7FFFFF,  17'd1000,   16'd100,   1'b0, 24'sd0},
    '{24'sh800000,  17'd1000,   16'd100,   1'b0, 24'sd0},
    '{24'sh7FFFFF,  17'd0,      16'd0,     1'b0, 24'sd0},
    '{24'sh800000,  17'd0,      16'd65535, 1'b0, 24'sd0},
    '{24'sd4096,    17'd24000,  16'd500,   1'b0, 24'sd0},
    '{-24'sd4096,   17'd23999,  16'd65535, 1'b0, 24'sd0},
    '{24'sh7FFFFF,  17'd96000,  16'd10,    1'b0, 24'sd0},
    '{24'sh800000,  17'd131071, 16'd1,     1'b0, 24'sd0},
    '{24'sd12345,   17'd12000,  16'd300,   1'b0, 24'sd0},
    '{-24'sd12345,  17'd12001,  16'd300,   1'b0, 24'sd0},
    '{24'sd700000,  17'd18000,  16'd2000,  1'b0, 24'sd0},
    '{-24'sd700000, 17'd6000,   16'd0,     1'b0, 24'sd0},
    '{24'sd1,       17'd1,      16'd1,     1'b0, 24'sd0},
    '{-24'sd1,      17'd440,    16'd65535, 1'b0, 24'sd0},
    '{24'sd0,       17'd440,    16'd65535, 1'b0, 24'sd0},
    '{24'sd0,       17'd440,    16'd65535, 1'b0, 24'sd0},
    '{24'sh7FFFFF,  17'd65536,  16'd32768, 1'b0, 24'sd0}
  };

  logic [NyqW-1:0] nyq_settings[5] = '{17'd24000, 17'd4000, 17'd96000, 17'd0, 17'd131071};

  initial begin
    nyq_reg = 24000;
    x_prev1 = 0;
    x_prev2 = 0;
    y_prev1 = 0;
    y_prev2 = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table at reset tuning
    foreach (directed[i]) send_item(directed[i]);

    // random phases, each with its own tuning and an idle pattern chosen by phase
    for (int p = 0; p < 5; p++) begin
      write_nyquist(nyq_settings[p]);
      idle_mode = idle_mode_e'(p % 4);
      repeat (RandPerPhase) send_item(random_row());
    end

    // drain and finish
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
